@@ hdl/grace_period_qs_tracker_assert.svh @@
// Assertion macros for the grace period tracker.
// Both sample on the rising edge of clk and are switched off during reset.
`ifndef GRACE_PERIOD_QS_TRACKER_ASSERT_SVH
`define GRACE_PERIOD_QS_TRACKER_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent
`define GPQS_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("gpqs check failed");

// Consequent must hold in the cycle after the antecedent
`define GPQS_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("gpqs check failed");

`endif

@@ hdl/gpqs_pkg.sv @@
package gpqs_pkg;

	// Topology
	localparam int NCPU      = 64;
	localparam int FANOUT    = 16;
	localparam int NLEAF     = (NCPU + FANOUT - 1) / FANOUT;
	localparam int FANOUT_LG = $clog2(FANOUT);
	localparam int LEAF_W    = (NLEAF > 1) ? $clog2(NLEAF) : 1;
	localparam int CPU_W     = 6;
	localparam int CNT_W     = 7;
	localparam int SEQ_W     = 32;
	localparam int DEPTH_W   = 8;

	// Request codes
	localparam logic [2:0] REQ_START  = 3'd0;
	localparam logic [2:0] REQ_TICK   = 3'd1;
	localparam logic [2:0] REQ_IDLE   = 3'd2;
	localparam logic [2:0] REQ_LOCK   = 3'd3;
	localparam logic [2:0] REQ_UNLOCK = 3'd4;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_BUSY  = 2'd1,
		ST_RANGE = 2'd2,
		ST_NEST  = 2'd3
	} status_t;

	// Per-processor word held in the state memory
	typedef struct packed {
		logic [SEQ_W-1:0]   seen_seq;
		logic               pending;
		logic [DEPTH_W-1:0] depth;
	} cpu_word_t;

	typedef struct packed {
		logic             en;
		logic [CPU_W-1:0] addr;
		cpu_word_t        data;
	} mem_wr_t;

	// One result word
	typedef struct packed {
		logic             accepted;
		logic             gp_completed;
		logic             gp_running;
		logic [SEQ_W-1:0] current_seq;
		logic [SEQ_W-1:0] finished_seq;
		logic             cpu_pending;
		status_t          status;
	} res_t;

endpackage

@@ hdl/gpqs_cpu_mem.sv @@
// Per-processor state memory: one write port, one registered read port.
// Entries never written read as zero through a valid bit per entry.
module gpqs_cpu_mem
	import gpqs_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             rd_en,
	input  logic [CPU_W-1:0] rd_addr,
	input  mem_wr_t          wr,
	output cpu_word_t        rd_data
);

	cpu_word_t        mem [NCPU];
	logic [NCPU-1:0]  valid_q;
	cpu_word_t        rd_data_q;

	// Storage write
	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
	end

	// Entry valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (wr.en) begin
			valid_q[wr.addr] <= 1'b1;
		end
	end

	// Registered read; a write to the same entry in the same cycle is passed through
	always_ff @(posedge clk) begin
		if (rd_en) begin
			if (wr.en && (wr.addr == rd_addr)) begin
				rd_data_q <= wr.data;
			end else if (valid_q[rd_addr]) begin
				rd_data_q <= mem[rd_addr];
			end else begin
				rd_data_q <= '0;
			end
		end
	end

	assign rd_data = rd_data_q;

endmodule

@@ hdl/gpqs_core.sv @@
// Event evaluation and the grace period tree: sequence counters, leaf masks, root mask.
module gpqs_core
	import gpqs_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             commit,
	input  logic [2:0]       req_type,
	input  logic [CPU_W-1:0] cpu,
	input  cpu_word_t        word_rd,
	input  logic [CNT_W-1:0] live,
	output mem_wr_t          wr,
	output res_t             res
);

	logic [SEQ_W-1:0]  seq_now_q, seq_done_q;
	logic              active_q;
	logic [FANOUT-1:0] leaf_q [NLEAF];
	logic [NLEAF-1:0]  root_q;

	logic [SEQ_W-1:0]  seq_now_d, seq_done_d;
	logic              active_d;
	logic [FANOUT-1:0] leaf_d [NLEAF];
	logic [NLEAF-1:0]  root_d;

	logic [FANOUT-1:0] start_mask [NLEAF];
	logic [LEAF_W-1:0] leaf_sel;
	logic [FANOUT_LG-1:0] bit_idx;
	logic              bit_set;
	logic [FANOUT-1:0] leaf_clr;
	logic [NLEAF-1:0]  root_clr;
	logic              in_range;
	cpu_word_t         word_new;
	logic              show, rep_try, acc, done;
	status_t           status;

	// Addressed leaf and bit
	assign leaf_sel = LEAF_W'(cpu >> FANOUT_LG);
	assign bit_idx  = cpu[FANOUT_LG-1:0];
	assign bit_set  = leaf_q[leaf_sel][bit_idx];
	assign in_range = {1'b0, cpu} < live;

	// Leaf and root after clearing the addressed bit
	always_comb begin
		leaf_clr          = leaf_q[leaf_sel];
		leaf_clr[bit_idx] = 1'b0;
		root_clr          = root_q;
		if (leaf_clr == '0) begin
			root_clr[leaf_sel] = 1'b0;
		end
	end

	// Masks loaded at the start of a period: one bit per live processor
	always_comb begin
		for (int i = 0; i < NLEAF; i++) begin
			for (int j = 0; j < FANOUT; j++) begin
				start_mask[i][j] = live > CNT_W'(i * FANOUT + j);
			end
		end
	end

	// Event evaluation
	always_comb begin
		seq_now_d  = seq_now_q;
		seq_done_d = seq_done_q;
		active_d   = active_q;
		leaf_d     = leaf_q;
		root_d     = root_q;
		word_new   = word_rd;
		show       = 1'b0;
		rep_try    = 1'b0;
		acc        = 1'b0;
		done       = 1'b0;
		status     = ST_OK;

		unique case (req_type)
			REQ_START: begin
				if (active_q) begin
					status = ST_BUSY;
				end else begin
					seq_now_d = seq_now_q + 1'b1;
					active_d  = 1'b1;
					leaf_d    = start_mask;
					for (int i = 0; i < NLEAF; i++) begin
						root_d[i] = |start_mask[i];
					end
					// no processors: the period ends at once
					if (live == '0) begin
						seq_done_d = seq_now_q + 1'b1;
						active_d   = 1'b0;
						done       = 1'b1;
					end
				end
			end
			REQ_TICK, REQ_IDLE, REQ_LOCK, REQ_UNLOCK: begin
				if (!in_range) begin
					status = ST_RANGE;
				end else begin
					show = 1'b1;
					unique case (req_type)
						REQ_TICK: begin
							if (word_rd.seen_seq != seq_now_q) begin
								word_new.pending = 1'b1;
							end
							word_new.seen_seq = seq_now_q;
							rep_try = word_new.pending && (word_rd.depth == '0);
						end
						REQ_IDLE: begin
							word_new.pending = 1'b0;
							rep_try = word_rd.pending;
						end
						REQ_LOCK: begin
							if (word_rd.depth == '1) begin
								status = ST_NEST;
							end else begin
								word_new.depth = word_rd.depth + 1'b1;
							end
						end
						default: begin
							if (word_rd.depth == '0) begin
								status = ST_NEST;
							end else begin
								word_new.depth = word_rd.depth - 1'b1;
							end
						end
					endcase
				end
			end
			default: begin
			end
		endcase

		// Quiescent report: clear leaf bit, then root bit, then finish the period
		if (rep_try && bit_set) begin
			acc              = 1'b1;
			word_new.pending = 1'b0;
			leaf_d[leaf_sel] = leaf_clr;
			root_d           = root_clr;
			if (root_clr == '0) begin
				seq_done_d = seq_now_q;
				active_d   = 1'b0;
				done       = 1'b1;
			end
		end
	end

	// Tree and sequence state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seq_now_q  <= '0;
			seq_done_q <= '0;
			active_q   <= 1'b0;
			root_q     <= '0;
			for (int i = 0; i < NLEAF; i++) begin
				leaf_q[i] <= '0;
			end
		end else if (commit) begin
			seq_now_q  <= seq_now_d;
			seq_done_q <= seq_done_d;
			active_q   <= active_d;
			root_q     <= root_d;
			leaf_q     <= leaf_d;
		end
	end

	// Write back the processor word and build the result
	always_comb begin
		wr.en   = commit && show;
		wr.addr = cpu;
		wr.data = word_new;

		res.accepted     = acc;
		res.gp_completed = done;
		res.gp_running   = active_d;
		res.current_seq  = seq_now_d;
		res.finished_seq = seq_done_d;
		res.cpu_pending  = show && word_new.pending;
		res.status       = status;
	end

endmodule

@@ hdl/grace_period_qs_tracker.sv @@
// Grace period tracker for read-copy-update over a two-level mask tree (leaves of FANOUT
// processors under a root mask). It takes one event word per clock cycle and returns one
// result word per event: the accepting edge registers the event and reads the addressed
// processor's word (last seen sequence, pending flag, reader nesting) from the state memory
// (one read port, one write port); the evaluation stage then evaluates the event against the
// tree, writes the word back and loads the result register. Back-to-back events to the same
// processor are forwarded around the memory. A result word left waiting holds the event
// behind it and so stalls the input. Memory entries read as zero until first written, so no
// clearing pass follows reset. The processor count comes through its own channel, always
// ready. The user must write it only while the block is idle; the block does not enforce it.
`include "grace_period_qs_tracker_assert.svh"

module grace_period_qs_tracker
	import gpqs_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	// configuration
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [CNT_W-1:0] cfg_data,
	// event channel
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [2:0]       req_type,
	input  logic [CPU_W-1:0] cpu,
	// result channel
	output logic             out_valid,
	input  logic             out_ready,
	output logic             accepted,
	output logic             gp_completed,
	output logic             gp_running,
	output logic [SEQ_W-1:0] current_seq,
	output logic [SEQ_W-1:0] finished_seq,
	output logic             cpu_pending,
	output logic [1:0]       status
);

	logic [CNT_W-1:0] cpu_count_q;
	logic [CNT_W-1:0] live;
	logic             valid_s1;
	logic [2:0]       req_type_s1;
	logic [CPU_W-1:0] cpu_s1;
	logic             out_valid_q;
	res_t             out_q;
	logic             in_acc, s1_adv;
	cpu_word_t        word_rd;
	mem_wr_t          wr;
	res_t             res;

	// Configuration register
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cpu_count_q <= CNT_W'(NCPU);
		end else if (cfg_valid && cfg_ready) begin
			cpu_count_q <= cfg_data;
		end
	end

	assign live = (cpu_count_q < CNT_W'(NCPU)) ? cpu_count_q : CNT_W'(NCPU);

	// Handshake
	assign s1_adv   = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || s1_adv;
	assign in_acc   = in_valid && in_ready;

	// Evaluation stage register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			req_type_s1 <= req_type;
			cpu_s1      <= cpu;
		end
	end

	gpqs_cpu_mem u_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (in_acc),
		.rd_addr (cpu),
		.wr      (wr),
		.rd_data (word_rd)
	);

	gpqs_core u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.commit   (s1_adv),
		.req_type (req_type_s1),
		.cpu      (cpu_s1),
		.word_rd  (word_rd),
		.live     (live),
		.wr       (wr),
		.res      (res)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_adv) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			out_q <= res;
		end
	end

	assign out_valid    = out_valid_q;
	assign accepted     = out_q.accepted;
	assign gp_completed = out_q.gp_completed;
	assign gp_running   = out_q.gp_running;
	assign current_seq  = out_q.current_seq;
	assign finished_seq = out_q.finished_seq;
	assign cpu_pending  = out_q.cpu_pending;
	assign status       = out_q.status;

	// Checks
	`GPQS_ASSERT_NOW(a_done_ends_period, out_valid && gp_completed,
		!gp_running && (current_seq == finished_seq))
	`GPQS_ASSERT_NOW(a_report_only_ok, out_valid && accepted, status == ST_OK)
	`GPQS_ASSERT_NOW(a_busy_is_running, out_valid && (status == ST_BUSY), gp_running)
	`GPQS_ASSERT_NEXT(a_eval_follows_accept, in_valid && in_ready, valid_s1)

endmodule
